>>> src/vzs_pkg.sv
package vzs_pkg;

  // operation codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_SHUT  = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  // configuration register indexes
  localparam logic CFG_RELEASE_SECONDS = 1'b0;
  localparam logic CFG_RELIEF_ZONE     = 1'b1;

  localparam int NUM_ZONES_DEF = 4;
  localparam int MAX_ZONES     = 16;
  localparam int OP_W          = 3;
  localparam int ZONE_W        = 4;
  localparam int DUR_W         = 16;
  localparam int ELAPSED_W     = 8;
  localparam int MASK_W        = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;
  localparam int RT_W          = 9;

  localparam logic [CFG_DATA_W-1:0] RELEASE_RESET = 8'd20;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } vzs_cmd_t;

endpackage

>>> src/vzs_in_if.sv
interface vzs_in_if import vzs_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [ZONE_W-1:0]    zone_index;
  logic [DUR_W-1:0]     duration;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, output op, output zone_index, output duration,
                  output elapsed, input ready);
  modport sink   (input valid, input op, input zone_index, input duration,
                  input elapsed, output ready);
endinterface

>>> src/vzs_out_if.sv
interface vzs_out_if import vzs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              status;
  logic [MASK_W-1:0] valve_mask;
  logic              master_open;
  logic [DUR_W-1:0]  zone_remaining;
  logic [MASK_W-1:0] forced_off_mask;
  logic              release_active;

  modport source (output valid, output status, output valve_mask, output master_open,
                  output zone_remaining, output forced_off_mask,
                  output release_active, input ready);
  modport sink   (input valid, input status, input valve_mask, input master_open,
                  input zone_remaining, input forced_off_mask,
                  input release_active, output ready);
endinterface

>>> src/vzs_ctrl.sv
module vzs_ctrl import vzs_pkg::*; #(
  parameter int NUM_ZONES = NUM_ZONES_DEF,
  parameter int ZW        = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output vzs_cmd_t      cmd,
  output logic [ZW-1:0] zone
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [ZW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          last_zone;
  logic          out_free;

  assign last_zone = (cnt_r == ZW'(NUM_ZONES - 1));
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (last_zone) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign zone      = cnt_r;
  assign out_valid = out_valid_r;

endmodule

>>> src/vzs_datapath.sv
module vzs_datapath import vzs_pkg::*; #(
  parameter int NUM_ZONES = NUM_ZONES_DEF,
  parameter int ZW        = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vzs_cmd_t              cmd,
  input  logic [ZW-1:0]         zone,
  input  logic [OP_W-1:0]       in_op,
  input  logic [ZONE_W-1:0]     in_zone_index,
  input  logic [DUR_W-1:0]      in_duration,
  input  logic [ELAPSED_W-1:0]  in_elapsed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_status,
  output logic [MASK_W-1:0]     out_valve_mask,
  output logic                  out_master_open,
  output logic [DUR_W-1:0]      out_zone_remaining,
  output logic [MASK_W-1:0]     out_forced_off_mask,
  output logic                  out_release_active
);

  // configuration
  logic [CFG_DATA_W-1:0] release_seconds_r;
  logic [ZONE_W-1:0]     relief_zone_r;

  // zone state
  logic [DUR_W-1:0]     rem_r [NUM_ZONES];
  logic [DUR_W-1:0]     rem_nxt [NUM_ZONES];
  logic [NUM_ZONES-1:0] open_r, open_nxt;
  logic                 master_r, master_nxt;
  logic signed [RT_W-1:0] rt_r, rt_nxt;

  // item being worked on
  logic [OP_W-1:0]      op_r;
  logic [ZONE_W-1:0]    zi_r;
  logic [DUR_W-1:0]     dur_r;
  logic [ELAPSED_W-1:0] el_r;

  // per-item scratch
  logic                 any_run_r, any_run_nxt;
  logic [NUM_ZONES-1:0] forced_r, forced_nxt;
  logic [DUR_W-1:0]     zrem_r, zrem_nxt;

  // result registers
  logic              status_r, status_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic              master_out_r, master_out_nxt;
  logic [DUR_W-1:0]  zrem_out_r, zrem_out_nxt;
  logic [MASK_W-1:0] forced_out_r, forced_out_nxt;
  logic              rel_act_r, rel_act_nxt;

  logic signed [RT_W:0]   rt_wide;
  logic signed [RT_W-1:0] rt_dec;
  logic [DUR_W-1:0]       rem_cur, rem_new, el_ext;
  logic                   known, zone_match, relief_known, addr_op;

  assign rt_wide = $signed({rt_r[RT_W-1], rt_r}) - $signed({2'b00, in_elapsed});
  assign rt_dec  = (rt_wide < -(RT_W+1)'(1)) ? -RT_W'(1) : rt_wide[RT_W-1:0];

  assign rem_cur      = rem_r[zone];
  assign el_ext       = DUR_W'(el_r);
  assign known        = ({1'b0, zi_r} < (ZONE_W+1)'(NUM_ZONES));
  assign zone_match   = (zi_r == ZONE_W'(zone));
  assign relief_known = ({1'b0, relief_zone_r} < (ZONE_W+1)'(NUM_ZONES));
  assign addr_op      = (op_r == OP_START) || (op_r == OP_STOP) || (op_r == OP_QUERY);

  always_comb begin
    rem_nxt        = rem_r;
    open_nxt       = open_r;
    master_nxt     = master_r;
    rt_nxt         = rt_r;
    any_run_nxt    = any_run_r;
    forced_nxt     = forced_r;
    zrem_nxt       = zrem_r;
    status_nxt     = status_r;
    mask_nxt       = mask_r;
    master_out_nxt = master_out_r;
    zrem_out_nxt   = zrem_out_r;
    forced_out_nxt = forced_out_r;
    rel_act_nxt    = rel_act_r;
    rem_new        = rem_cur;

    if (cmd.load) begin
      any_run_nxt = 1'b0;
      forced_nxt  = '0;
      zrem_nxt    = '0;
      if (in_op == OP_TICK) begin
        rt_nxt = rt_dec;
      end
    end

    // one zone per cycle
    if (cmd.step) begin
      case (op_r)
        OP_START: begin
          if (known) begin
            if (zone_match) begin
              rem_new = dur_r;
            end else if (rem_cur != '0) begin
              rem_new          = '0;
              forced_nxt[zone] = 1'b1;
            end
          end
        end
        OP_STOP: begin
          if (known && zone_match) begin
            rem_new = '0;
          end
        end
        OP_TICK: begin
          rem_new = (rem_cur > el_ext) ? rem_cur - el_ext : '0;
          if (rem_new != '0) begin
            open_nxt[zone] = 1'b1;
            any_run_nxt    = 1'b1;
          end else if (rt_r[RT_W-1] || (relief_zone_r != ZONE_W'(zone))) begin
            open_nxt[zone] = 1'b0;
          end
        end
        OP_SHUT: begin
          open_nxt[zone] = 1'b0;
        end
        default: begin
        end
      endcase
      rem_nxt[zone] = rem_new;
      if (zone_match) begin
        zrem_nxt = rem_new;
      end
    end

    if (cmd.finish) begin
      if (op_r == OP_TICK) begin
        if (any_run_r) begin
          master_nxt = 1'b1;
          rt_nxt     = '0;
        end else if (master_r) begin
          master_nxt = 1'b0;
          rt_nxt     = $signed({1'b0, release_seconds_r});
          for (int i = 0; i < NUM_ZONES; i++) begin
            if (relief_known && (relief_zone_r == ZONE_W'(i))) begin
              open_nxt[i] = 1'b1;
            end
          end
        end
      end else if (op_r == OP_SHUT) begin
        master_nxt = 1'b0;
      end
      status_nxt     = addr_op && !known;
      mask_nxt       = MASK_W'(open_nxt);
      master_out_nxt = master_nxt;
      zrem_out_nxt   = zrem_r;
      forced_out_nxt = MASK_W'(forced_r);
      rel_act_nxt    = !rt_nxt[RT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_seconds_r <= RELEASE_RESET;
      relief_zone_r     <= '0;
      for (int i = 0; i < NUM_ZONES; i++) begin
        rem_r[i] <= '0;
      end
      open_r   <= '0;
      master_r <= 1'b0;
      rt_r     <= -RT_W'(1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RELEASE_SECONDS: release_seconds_r <= cfg_data;
          CFG_RELIEF_ZONE:     relief_zone_r     <= cfg_data[ZONE_W-1:0];
          default: begin
          end
        endcase
      end
      rem_r    <= rem_nxt;
      open_r   <= open_nxt;
      master_r <= master_nxt;
      rt_r     <= rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      zi_r  <= in_zone_index;
      dur_r <= in_duration;
      el_r  <= in_elapsed;
    end
    any_run_r    <= any_run_nxt;
    forced_r     <= forced_nxt;
    zrem_r       <= zrem_nxt;
    status_r     <= status_nxt;
    mask_r       <= mask_nxt;
    master_out_r <= master_out_nxt;
    zrem_out_r   <= zrem_out_nxt;
    forced_out_r <= forced_out_nxt;
    rel_act_r    <= rel_act_nxt;
  end

  assign out_status          = status_r;
  assign out_valve_mask      = mask_r;
  assign out_master_open     = master_out_r;
  assign out_zone_remaining  = zrem_out_r;
  assign out_forced_off_mask = forced_out_r;
  assign out_release_active  = rel_act_r;

endmodule

>>> src/valve_zone_sequencer_unit.sv
// a new request is taken only after the zone walk and finish step of the last one,
//   a walk that visits one zone countdown per cycle through a single subtractor
// the next request is taken while a result still waits in the output register
// reset: synchronous active-low rst_n clears countdowns, valves and master,
//   sets the release timer expired and loads release_seconds 20, relief_zone 0
module valve_zone_sequencer_unit import vzs_pkg::*; #(
  parameter int NUM_ZONES = NUM_ZONES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vzs_in_if.sink                in_ch,
  vzs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // zone counter width, at least one bit for a single zone
  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

  vzs_cmd_t      cmd;
  logic [ZW-1:0] zone;

  // controller: idle -> walk over zones -> finish into output register
  vzs_ctrl #(
    .NUM_ZONES (NUM_ZONES),
    .ZW        (ZW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .zone      (zone)
  );

  // datapath: countdowns, valve flags, master, release timer, config and results
  vzs_datapath #(
    .NUM_ZONES (NUM_ZONES),
    .ZW        (ZW)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .zone                (zone),
    .in_op               (in_ch.op),
    .in_zone_index       (in_ch.zone_index),
    .in_duration         (in_ch.duration),
    .in_elapsed          (in_ch.elapsed),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_status          (out_ch.status),
    .out_valve_mask      (out_ch.valve_mask),
    .out_master_open     (out_ch.master_open),
    .out_zone_remaining  (out_ch.zone_remaining),
    .out_forced_off_mask (out_ch.forced_off_mask),
    .out_release_active  (out_ch.release_active)
  );

endmodule

>>> src/vzs_checker.sv
module vzs_assertions import vzs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_status,
  input logic [MASK_W-1:0] out_forced_off_mask
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a waiting result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before accept");

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in work");

  // forced zones only come from a start of a known zone
  a_forced_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_forced_off_mask != '0) |-> !out_status)
    else $error("forced mask with unknown zone status");

endmodule

bind valve_zone_sequencer_unit vzs_assertions u_vzs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_status          (out_ch.status),
  .out_forced_off_mask (out_ch.forced_off_mask)
);
